// File: rtl/fmma_pkg.sv
`timescale 1ns / 1ps
package fmma_pkg;

  localparam int VAL_W = 32;
  localparam int LEN_W = 33;
  localparam int PTR_W = 13;

  localparam logic [2:0] CMD_LOAD_ROW = 3'd0;
  localparam logic [2:0] CMD_LOAD_COL = 3'd1;
  localparam logic [2:0] CMD_CLEAR    = 3'd2;
  localparam logic [2:0] CMD_ADD      = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISSING = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;
  localparam logic [1:0] STAT_SAT     = 2'd3;

  typedef struct packed {
    logic [2:0]              command;
    logic [11:0]             slot;
    logic [PTR_W-1:0]        load_word;
    logic [9:0]              node_first;
    logic [9:0]              node_second;
    logic signed [VAL_W-1:0] coord_first;
    logic signed [VAL_W-1:0] coord_second;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [1:0]              status;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_ROW_S,
    ST_ROW_E,
    ST_ROW_W,
    ST_SCAN,
    ST_CHECK,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_READ,
    ST_FIN
  } state_e;

endpackage

// File: rtl/fmma_scaler.sv
`timescale 1ns / 1ps
// Rounded |len|/3 and |len|/6 by reciprocal multiplication, split into a low-slice and a high-slice partial product.
// floor(x/6) is taken as floor(floor(x/2)/3), so both quotients share one reciprocal.
module fmma_scaler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [fmma_pkg::LEN_W-1:0] len_i,
  output logic                              done_o,
  output logic signed [fmma_pkg::VAL_W-1:0] third_o,
  output logic signed [fmma_pkg::VAL_W-1:0] sixth_o
);
  localparam int LW = fmma_pkg::LEN_W;
  localparam int VW = fmma_pkg::VAL_W;
  localparam int HW = 17;
  localparam int MW = LW + HW;
  localparam int PW = 2 * LW;
  localparam int SH = 34;
  // ceil(2^34 / 3): exact floor quotient for every dividend below 2^33
  localparam logic [LW-1:0]    RECIP    = 33'h155555556;
  localparam logic [HW-1:0]    RECIP_LO = RECIP[HW-1:0];
  localparam logic [LW-HW-1:0] RECIP_HI = RECIP[LW-1:HW];

  logic          busy_q, busy_d;
  logic          phase_q, phase_d;
  logic          done_q, done_d;
  logic          neg_q, neg_d;
  logic [LW-1:0] a3_q, a3_d, a6_q, a6_d;
  logic [PW-1:0] p3_q, p3_d, p6_q, p6_d;
  logic [LW-1:0] mag, mag3;
  logic [HW-1:0] coef;
  logic [MW-1:0] part3, part6;

  assign mag   = len_i[LW-1] ? LW'(-len_i) : LW'(len_i);
  assign mag3  = mag + LW'(3);
  // low slice of the reciprocal first, high slice second
  assign coef  = phase_q ? HW'(RECIP_HI) : RECIP_LO;
  assign part3 = MW'(a3_q) * MW'(coef);
  assign part6 = MW'(a6_q) * MW'(coef);

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    done_d  = done_q;
    neg_d   = neg_q;
    a3_d    = a3_q;
    a6_d    = a6_q;
    p3_d    = p3_q;
    p6_d    = p6_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      done_d  = 1'b0;
      neg_d   = len_i[LW-1];
      // round half away from zero: add half the divisor before truncating
      a3_d    = mag + LW'(1);
      a6_d    = {1'b0, mag3[LW-1:1]};
    end else if (busy_q) begin
      phase_d = 1'b1;
      if (!phase_q) begin
        p3_d = PW'(part3);
        p6_d = PW'(part6);
      end else begin
        p3_d   = p3_q + (PW'(part3) << HW);
        p6_d   = p6_q + (PW'(part6) << HW);
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    a3_q  <= a3_d;
    a6_q  <= a6_d;
    p3_q  <= p3_d;
    p6_q  <= p6_d;
  end

  assign done_o  = done_q;
  assign third_o = neg_q ? -$signed(p3_q[SH+VW-1:SH]) : $signed(p3_q[SH+VW-1:SH]);
  assign sixth_o = neg_q ? -$signed(p6_q[SH+VW-1:SH]) : $signed(p6_q[SH+VW-1:SH]);

endmodule

// File: rtl/fem_mass_matrix_csr_assembler.sv
`timescale 1ns / 1ps
// One transaction at a time; the next input can be taken in the same cycle as the result appears.
// A clear sweeps all MAX_ENTRIES value entries to zero before its result. An add element
// reads the start and end of both rows, scans the column entries of each row and then does
// four value read-modify-writes; a missing column ends after the scans. After reset the
// value memory is swept to zero with stall high.
module fem_mass_matrix_csr_assembler #(
  parameter int MAX_NODES   = 1024,
  parameter int MAX_ENTRIES = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  fmma_pkg::item_t           in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output fmma_pkg::result_t         out_result_o
);
  localparam int RW = $clog2(MAX_NODES + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int PW = fmma_pkg::PTR_W;
  localparam int VW = fmma_pkg::VAL_W;
  localparam int LW = fmma_pkg::LEN_W;

  // memories
  logic [PW-1:0]        rs_mem  [MAX_NODES+1];
  logic [PW-1:0]        col_mem [MAX_ENTRIES];
  logic signed [VW-1:0] val_mem [MAX_ENTRIES];

  logic                 rs_we, col_we, val_we;
  logic [RW-1:0]        rs_waddr, rs_raddr;
  logic [AW-1:0]        col_waddr, col_raddr, val_waddr, val_raddr;
  logic [PW-1:0]        rs_rdata_q, col_rdata_q;
  logic signed [VW-1:0] val_wdata, val_rdata_q;

  fmma_pkg::state_e     state_q, state_d;
  fmma_pkg::item_t      item_q, item_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic                 clr_reply_q, clr_reply_d;
  logic [PW-1:0]        j_q, j_d, end_q, end_d;
  logic                 row_q, row_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        pend_idx_q, pend_idx_d;
  logic [AW-1:0]        hit_q [4];
  logic [AW-1:0]        hit_d [4];
  logic [3:0]           found_q, found_d;
  logic [1:0]           k_q, k_d;
  logic                 clip_q, clip_d;
  logic signed [VW-1:0] res_value_q, res_value_d;
  logic [1:0]           res_status_q, res_status_d;
  logic                 out_vld_q, out_vld_d;
  fmma_pkg::result_t    out_q, out_d;

  logic                 accept, out_free, scan_end, clr_last, clip_now;
  logic                 rs_bad, col_bad, add_bad, rd_bad;
  logic [9:0]           row_node;
  logic [PW-1:0]        end_clamp;
  logic                 sc_start, sc_done;
  logic signed [LW-1:0] sc_len;
  logic signed [VW-1:0] sc_third, sc_sixth, addend, sat_val;
  logic signed [LW-1:0] sum;

  assign accept   = in_valid_i && (state_q == fmma_pkg::ST_IDLE);
  assign out_free = !out_vld_q || !out_stall_i;
  assign scan_end = (j_q >= end_q) && !pend_q;
  assign clr_last = (clr_q == AW'(MAX_ENTRIES - 1));
  assign rs_bad   = 32'(item_q.slot) > MAX_NODES;
  assign col_bad  = (32'(item_q.slot) >= MAX_ENTRIES) || (32'(item_q.load_word) >= MAX_NODES);
  assign add_bad  = (32'(item_q.node_first) >= MAX_NODES) ||
                    (32'(item_q.node_second) >= MAX_NODES);
  assign rd_bad   = 32'(item_q.slot) >= MAX_ENTRIES;
  assign row_node = row_q ? item_q.node_second : item_q.node_first;
  assign end_clamp = (32'(rs_rdata_q) > MAX_ENTRIES) ? PW'(MAX_ENTRIES) : rs_rdata_q;

  assign sc_start = (state_q == fmma_pkg::ST_EXEC) &&
                    (item_q.command == fmma_pkg::CMD_ADD) && !add_bad;
  assign sc_len   = {item_q.coord_second[VW-1], item_q.coord_second} -
                    {item_q.coord_first[VW-1], item_q.coord_first};

  fmma_scaler u_scaler (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sc_start),
    .len_i   (sc_len),
    .done_o  (sc_done),
    .third_o (sc_third),
    .sixth_o (sc_sixth)
  );

  // diagonals take length/3, off-diagonals length/6
  assign addend   = (k_q == 2'd0 || k_q == 2'd3) ? sc_third : sc_sixth;
  assign sum      = {val_rdata_q[VW-1], val_rdata_q} + {addend[VW-1], addend};
  assign clip_now = sum[LW-1] != sum[LW-2];
  assign sat_val  = clip_now ? (sum[LW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
                             : sum[VW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fmma_pkg::ST_IDLE: if (accept) state_d = fmma_pkg::ST_EXEC;
      fmma_pkg::ST_EXEC: begin
        unique case (item_q.command) inside
          fmma_pkg::CMD_CLEAR: state_d = fmma_pkg::ST_CLEAR;
          fmma_pkg::CMD_ADD:   state_d = add_bad ? fmma_pkg::ST_FIN : fmma_pkg::ST_ROW_S;
          fmma_pkg::CMD_READ:  state_d = rd_bad ? fmma_pkg::ST_FIN : fmma_pkg::ST_READ;
          default:             state_d = fmma_pkg::ST_FIN;
        endcase
      end
      fmma_pkg::ST_CLEAR: begin
        if (clr_last) state_d = clr_reply_q ? fmma_pkg::ST_FIN : fmma_pkg::ST_IDLE;
      end
      fmma_pkg::ST_ROW_S: state_d = fmma_pkg::ST_ROW_E;
      fmma_pkg::ST_ROW_E: state_d = fmma_pkg::ST_ROW_W;
      fmma_pkg::ST_ROW_W: state_d = fmma_pkg::ST_SCAN;
      fmma_pkg::ST_SCAN: begin
        if (scan_end) state_d = row_q ? fmma_pkg::ST_CHECK : fmma_pkg::ST_ROW_S;
      end
      fmma_pkg::ST_CHECK: begin
        if (found_q != 4'hf)  state_d = fmma_pkg::ST_FIN;
        else if (sc_done)     state_d = fmma_pkg::ST_RMW_RD;
      end
      fmma_pkg::ST_RMW_RD: state_d = fmma_pkg::ST_RMW_WR;
      fmma_pkg::ST_RMW_WR: state_d = (k_q == 2'd3) ? fmma_pkg::ST_FIN : fmma_pkg::ST_RMW_RD;
      fmma_pkg::ST_READ:   state_d = fmma_pkg::ST_FIN;
      fmma_pkg::ST_FIN:    if (out_free) state_d = fmma_pkg::ST_IDLE;
      default:             state_d = fmma_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    item_d       = item_q;
    clr_d        = clr_q;
    clr_reply_d  = clr_reply_q;
    j_d          = j_q;
    end_d        = end_q;
    row_d        = row_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    hit_d        = hit_q;
    found_d      = found_q;
    k_d          = k_q;
    clip_d       = clip_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_d        = out_q;
    out_vld_d    = out_vld_q && out_stall_i;
    rs_we        = 1'b0;
    rs_waddr     = RW'(item_q.slot);
    rs_raddr     = RW'(row_node);
    col_we       = 1'b0;
    col_waddr    = AW'(item_q.slot);
    col_raddr    = AW'(j_q);
    val_we       = 1'b0;
    val_waddr    = clr_q;
    val_wdata    = '0;
    val_raddr    = AW'(item_q.slot);
    unique case (state_q)
      fmma_pkg::ST_IDLE: if (accept) item_d = in_item_i;
      fmma_pkg::ST_EXEC: begin
        res_value_d  = '0;
        res_status_d = fmma_pkg::STAT_OK;
        row_d        = 1'b0;
        found_d      = '0;
        k_d          = '0;
        clip_d       = 1'b0;
        clr_d        = '0;
        clr_reply_d  = 1'b1;
        unique case (item_q.command) inside
          fmma_pkg::CMD_LOAD_ROW: begin
            if (rs_bad) res_status_d = fmma_pkg::STAT_RANGE;
            else rs_we = 1'b1;
          end
          fmma_pkg::CMD_LOAD_COL: begin
            if (col_bad) res_status_d = fmma_pkg::STAT_RANGE;
            else col_we = 1'b1;
          end
          fmma_pkg::CMD_ADD:  if (add_bad) res_status_d = fmma_pkg::STAT_RANGE;
          fmma_pkg::CMD_READ: if (rd_bad) res_status_d = fmma_pkg::STAT_RANGE;
          default: ;
        endcase
      end
      fmma_pkg::ST_CLEAR: begin
        val_we = 1'b1;
        clr_d  = clr_q + AW'(1);
      end
      fmma_pkg::ST_ROW_S: ;
      fmma_pkg::ST_ROW_E: begin
        rs_raddr = RW'(row_node) + RW'(1);
        j_d      = rs_rdata_q;
      end
      fmma_pkg::ST_ROW_W: end_d = end_clamp;
      fmma_pkg::ST_SCAN: begin
        if (j_q < end_q) begin
          pend_d     = 1'b1;
          pend_idx_d = AW'(j_q);
          j_d        = j_q + PW'(1);
        end
        // later entries overwrite earlier hits: last occurrence wins
        if (pend_q) begin
          if (col_rdata_q == PW'(item_q.node_first)) begin
            hit_d[{row_q, 1'b0}]   = pend_idx_q;
            found_d[{row_q, 1'b0}] = 1'b1;
          end
          if (col_rdata_q == PW'(item_q.node_second)) begin
            hit_d[{row_q, 1'b1}]   = pend_idx_q;
            found_d[{row_q, 1'b1}] = 1'b1;
          end
        end
        if (scan_end) row_d = 1'b1;
      end
      fmma_pkg::ST_CHECK: if (found_q != 4'hf) res_status_d = fmma_pkg::STAT_MISSING;
      fmma_pkg::ST_RMW_RD: val_raddr = hit_q[k_q];
      fmma_pkg::ST_RMW_WR: begin
        val_we    = 1'b1;
        val_waddr = hit_q[k_q];
        val_wdata = sat_val;
        clip_d    = clip_q || clip_now;
        k_d       = k_q + 2'd1;
        if (k_q == 2'd3 && (clip_q || clip_now)) res_status_d = fmma_pkg::STAT_SAT;
      end
      fmma_pkg::ST_READ: res_value_d = val_rdata_q;
      fmma_pkg::ST_FIN: begin
        if (out_free) begin
          out_vld_d         = 1'b1;
          out_d.read_value  = res_value_q;
          out_d.status      = res_status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) rs_mem[rs_waddr] <= item_q.load_word;
    rs_rdata_q <= rs_mem[rs_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[col_waddr] <= item_q.load_word;
    col_rdata_q <= col_mem[col_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_waddr] <= val_wdata;
    val_rdata_q <= val_mem[val_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fmma_pkg::ST_CLEAR;
      clr_q       <= '0;
      clr_reply_q <= 1'b0;
      row_q       <= 1'b0;
      pend_q      <= 1'b0;
      found_q     <= '0;
      k_q         <= '0;
      clip_q      <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_reply_q <= clr_reply_d;
      row_q       <= row_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      k_q         <= k_d;
      clip_q      <= clip_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    j_q          <= j_d;
    end_q        <= end_d;
    pend_idx_q   <= pend_idx_d;
    hit_q        <= hit_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  assign in_stall_o   = state_q != fmma_pkg::ST_IDLE;
  assign out_valid_o  = out_vld_q;
  assign out_result_o = out_q;

endmodule

// File: tb/fem_mass_matrix_csr_assembler_tb.sv
`timescale 1ns / 1ps
module fem_mass_matrix_csr_assembler_tb;

  localparam int NODES      = 1024;
  localparam int ENTRIES    = 4096;
  localparam int CYCLE_CAP  = 2_000_000;
  localparam int RAND_ITEMS = 1400;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;

  // Tracks the CSR store and the values, and predicts each status/value pair.
  class mass_matrix_tracker;
    logic [12:0]        row_ptr [0:NODES];
    bit                 row_set [0:NODES];
    logic [9:0]         col_node[0:ENTRIES-1];
    bit                 col_set [0:ENTRIES-1];
    int                 acc     [0:ENTRIES-1];
    fmma_pkg::result_t  pending [$];
    int                 errors;

    function new();
      errors = 0;
      foreach (acc[i]) acc[i] = 0;
    endfunction

    // row of n fully defined, so a scan never touches an unwritten entry
    function bit node_ready(int n);
      int e;
      if (n >= NODES || !row_set[n] || !row_set[n+1]) return 0;
      e = int'(row_ptr[n+1]);
      if (e > ENTRIES) e = ENTRIES;
      for (int j = int'(row_ptr[n]); j < e; j++)
        if (!col_set[j]) return 0;
      return 1;
    endfunction

    function int find_entry(int n, int c);
      int e;
      int hit;
      hit = -1;
      e = int'(row_ptr[n+1]);
      if (e > ENTRIES) e = ENTRIES;
      for (int j = int'(row_ptr[n]); j < e; j++)
        if (int'(col_node[j]) == c) hit = j;
      return hit;
    endfunction

    function longint div_nearest(longint len, longint d);
      longint mag;
      longint q;
      mag = (len < 0) ? -len : len;
      q = (mag + d / 2) / d;
      return (len < 0) ? -q : q;
    endfunction

    function bit acc_sat(int idx, longint inc);
      longint s;
      bit clip;
      clip = 0;
      s = longint'(acc[idx]) + inc;
      if (s > 64'sd2147483647) begin
        s = 64'sd2147483647;
        clip = 1;
      end
      if (s < -64'sd2147483648) begin
        s = -64'sd2147483648;
        clip = 1;
      end
      acc[idx] = int'(s);
      return clip;
    endfunction

    function void note_command(fmma_pkg::item_t it);
      fmma_pkg::result_t r;
      int n0, n1, ad, ao, bo, bd;
      longint len, third, sixth;
      bit clip;
      r.read_value = '0;
      r.status = fmma_pkg::STAT_OK;
      n0 = int'(it.node_first);
      n1 = int'(it.node_second);
      case (it.command)
        fmma_pkg::CMD_LOAD_ROW: begin
          if (int'(it.slot) > NODES) r.status = fmma_pkg::STAT_RANGE;
          else begin
            row_ptr[it.slot] = it.load_word;
            row_set[it.slot] = 1;
          end
        end
        fmma_pkg::CMD_LOAD_COL: begin
          if (int'(it.load_word) >= NODES) r.status = fmma_pkg::STAT_RANGE;
          else begin
            col_node[it.slot] = it.load_word[9:0];
            col_set[it.slot] = 1;
          end
        end
        fmma_pkg::CMD_CLEAR: foreach (acc[i]) acc[i] = 0;
        fmma_pkg::CMD_ADD: begin
          if (n0 >= NODES || n1 >= NODES) r.status = fmma_pkg::STAT_RANGE;
          else begin
            len = longint'($signed(it.coord_second)) - longint'($signed(it.coord_first));
            third = div_nearest(len, 3);
            sixth = div_nearest(len, 6);
            ad = find_entry(n0, n0);
            ao = find_entry(n0, n1);
            bo = find_entry(n1, n0);
            bd = find_entry(n1, n1);
            if (ad < 0 || ao < 0 || bo < 0 || bd < 0) r.status = fmma_pkg::STAT_MISSING;
            else begin
              clip = acc_sat(ad, third);
              clip |= acc_sat(ao, sixth);
              clip |= acc_sat(bo, sixth);
              clip |= acc_sat(bd, third);
              if (clip) r.status = fmma_pkg::STAT_SAT;
            end
          end
        end
        fmma_pkg::CMD_READ: r.read_value = acc[it.slot];
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(fmma_pkg::result_t got);
      fmma_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0d", $time,
                 got.read_value, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %0d actual %0d", $time,
                 want.read_value, got.read_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  fmma_pkg::item_t   in_item_i;
  logic              out_valid_o;
  logic              out_stall_i;
  fmma_pkg::result_t out_result_o;

  mass_matrix_tracker tracker;
  int  cycles = 0;
  bit  in_burst;
  bit  out_burst;
  int  sent_count;
  int  mesh_b_end;

  fem_mass_matrix_csr_assembler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_result_o(out_result_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic fmma_pkg::item_t mk(logic [2:0] cmd, int slot, int word);
    fmma_pkg::item_t it;
    it.command      = cmd;
    it.slot         = 12'(slot);
    it.load_word    = 13'(word);
    it.node_first   = 10'($urandom);
    it.node_second  = 10'($urandom);
    it.coord_first  = $urandom;
    it.coord_second = $urandom;
    return it;
  endfunction

  function automatic fmma_pkg::item_t mk_elem(int n0, int n1, int c0, int c1);
    fmma_pkg::item_t it;
    it = mk(fmma_pkg::CMD_ADD, $urandom, $urandom);
    it.node_first   = 10'(n0);
    it.node_second  = 10'(n1);
    it.coord_first  = c0;
    it.coord_second = c1;
    return it;
  endfunction

  // mostly short elements so the accumulators rarely pin
  function automatic fmma_pkg::item_t rand_elem(int n0, int n1);
    int c0;
    c0 = $urandom;
    if ($urandom_range(9) == 0) return mk_elem(n0, n1, c0, $urandom);
    return mk_elem(n0, n1, c0, c0 + $urandom_range(2097152) - 1048576);
  endfunction

  task automatic send(fmma_pkg::item_t it);
    int gap;
    gap = in_burst ? 0 : $urandom_range(8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    tracker.note_command(it);
    sent_count++;
    if (sent_count % 150 == 0) in_burst = ($urandom_range(3) == 0);
  endtask

  // tridiagonal rows with their columns in shuffled order, sometimes with a repeated column
  task automatic load_mesh(int first, int count, int base, output int ptr);
    int cols[$];
    ptr = base;
    for (int n = first; n < first + count; n++) begin
      cols.delete();
      if (n > first) cols.push_back(n - 1);
      cols.push_back(n);
      if (n < first + count - 1) cols.push_back(n + 1);
      cols.shuffle();
      if ($urandom_range(3) == 0) cols.push_back(cols[$urandom_range(cols.size() - 1)]);
      send(mk(fmma_pkg::CMD_LOAD_ROW, n, ptr));
      foreach (cols[k]) begin
        send(mk(fmma_pkg::CMD_LOAD_COL, ptr, cols[k]));
        ptr++;
      end
    end
    send(mk(fmma_pkg::CMD_LOAD_ROW, first + count, ptr));
  endtask

  task automatic pick_pair(output int n0, output int n1);
    int lo, cnt, d;
    if ($urandom_range(2) == 0) begin
      lo = 1000;
      cnt = 24;
    end else begin
      lo = 0;
      cnt = 40;
    end
    n0 = lo + $urandom_range(cnt - 1);
    d = $urandom_range(2);
    n1 = (d == 0) ? n0 : (d == 1) ? n0 + 1 : n0 - 1;
    if (n1 < lo || n1 >= lo + cnt) n1 = n0;
  endtask

  initial begin : result_side
    int stall;
    int got_count;
    fmma_pkg::result_t got;
    got_count = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = out_burst ? 0 : $urandom_range(8);
      if (stall > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(negedge clk_i);
      while (!out_valid_o) @(negedge clk_i);
      got = out_result_o;
      @(posedge clk_i);
      tracker.check_result(got);
      got_count++;
      if (got_count % 150 == 0) out_burst = ($urandom_range(3) == 0);
    end
  end

  initial begin : stimulus
    int n0, n1, r, ptr, c;
    tracker = new();
    sent_count = 0;
    in_burst = 0;
    out_burst = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_mesh(0, 40, 0, ptr);
    load_mesh(1000, 24, 3900, mesh_b_end);

    // directed: ranges, spare commands, clamped last row, rounding, saturation
    for (int k = int'(CMD_SPARE_LO); k <= 7; k++) send(mk(k[2:0], $urandom, $urandom));
    send(mk(fmma_pkg::CMD_LOAD_ROW, NODES + 1, 0));
    send(mk(fmma_pkg::CMD_LOAD_ROW, 4095, 8191));
    send(mk(fmma_pkg::CMD_LOAD_COL, 10, 1024));
    send(mk(fmma_pkg::CMD_LOAD_COL, 10, 8191));
    for (int j = mesh_b_end; j < ENTRIES - 1; j++) send(mk(fmma_pkg::CMD_LOAD_COL, j, 0));
    send(mk(fmma_pkg::CMD_LOAD_COL, 4095, 1023));
    send(mk(fmma_pkg::CMD_LOAD_ROW, NODES, 8191));
    send(mk(fmma_pkg::CMD_READ, 0, 0));
    send(mk(fmma_pkg::CMD_READ, 4095, 0));
    send(mk_elem(0, 5, 0, 65536));
    send(mk_elem(3, 3, 0, 3));
    send(mk_elem(1, 2, 0, 3));
    send(mk_elem(2, 1, 3, 0));
    send(mk_elem(4, 5, 100, 109));
    send(mk_elem(1022, 1023, 32'h80000000, 32'h7fffffff));
    send(mk_elem(1023, 1022, 32'h80000000, 32'h7fffffff));
    send(mk_elem(1023, 1023, 32'h7fffffff, 32'h80000000));
    for (int k = 0; k < 3; k++) send(mk_elem(1022, 1023, 32'h7fffffff, 32'h80000000));
    send(mk(fmma_pkg::CMD_READ, 4095, 0));
    send(mk(fmma_pkg::CMD_CLEAR, $urandom, $urandom));
    send(mk(fmma_pkg::CMD_READ, 4095, 0));

    for (int i = 0; i < RAND_ITEMS; i++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        pick_pair(n0, n1);
        if (tracker.node_ready(n0) && tracker.node_ready(n1)) send(rand_elem(n0, n1));
        else send(mk(fmma_pkg::CMD_READ, $urandom_range(ENTRIES - 1), 0));
      end else if (r < 63) begin
        n0 = $urandom_range(37);
        n1 = n0 + 2 + $urandom_range(37 - n0);
        if ($urandom_range(1)) send(rand_elem(n0, n1));
        else send(rand_elem(n1, n0));
      end else if (r < 83) begin
        c = $urandom_range(3) == 0 ? $urandom_range(ENTRIES - 1) : $urandom_range(ptr - 1);
        send(mk(fmma_pkg::CMD_READ, c, 0));
      end else if (r < 88) begin
        send(mk(fmma_pkg::CMD_LOAD_COL, 2000 + $urandom_range(999), $urandom_range(8191)));
      end else if (r < 93) begin
        if ($urandom_range(1)) send(mk(fmma_pkg::CMD_LOAD_ROW, 500 + $urandom_range(400),
                                       $urandom_range(8191)));
        else send(mk(fmma_pkg::CMD_LOAD_ROW, NODES + 1 + $urandom_range(4095 - NODES - 1),
                     $urandom_range(8191)));
      end else if (r < 96) begin
        send(mk(3'(CMD_SPARE_LO + $urandom_range(2)), $urandom, $urandom));
      end else if (r < 97) begin
        send(mk(fmma_pkg::CMD_CLEAR, $urandom, $urandom));
      end else begin
        n0 = $urandom_range(NODES - 1);
        n1 = $urandom_range(NODES - 1);
        if (tracker.node_ready(n0) && tracker.node_ready(n1)) send(rand_elem(n0, n1));
        else send(mk(fmma_pkg::CMD_READ, $urandom_range(ENTRIES - 1), 0));
      end
    end

    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (tracker.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: fem_mass_matrix_csr_assembler.f
rtl/fmma_pkg.sv
rtl/fmma_scaler.sv
rtl/fem_mass_matrix_csr_assembler.sv
tb/fem_mass_matrix_csr_assembler_tb.sv
